[hdl/dtyp_pkg.sv]
// Shared types and constants for the direction-to-yaw/pitch converter.
// Holds the CORDIC arctangent table, the gain-correction constant and the
// fixed internal widths. Used by every module of the block.
package dtyp_pkg;

  // Angle accumulator: signed degrees with 30 fraction bits.
  localparam int unsigned ACC_FRAC = 30;
  localparam int unsigned ACC_W    = 41;

  // Vector datapath: signed, wide enough for the normalized inputs
  // plus the CORDIC growth of both passes.
  localparam int unsigned VEC_W    = 35;

  // Normalization brings the largest magnitude up to this bit position.
  localparam int unsigned NORM_MSB = 30;
  localparam int unsigned SHIFT_W  = 5;

  // Gain correction: 1/K in Q.30, applied as two partial products.
  localparam int unsigned KINV_W    = 30;
  localparam int unsigned GAIN_LO_W = (VEC_W - 1) / 2;
  localparam int unsigned GAIN_HI_W = VEC_W - 1 - GAIN_LO_W;
  localparam int unsigned PP_LO_W   = GAIN_LO_W + KINV_W;
  localparam int unsigned PP_HI_W   = GAIN_HI_W + KINV_W;
  localparam int unsigned PROD_W    = VEC_W - 1 + KINV_W;
  localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;

  // 180 degrees in accumulator format.
  localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 41'sd193273528320;

  // atan(2^-i) in degrees, Q.30.
  localparam logic signed [ACC_W-1:0] ATAN_DEG [32] = '{
    41'sd48318382080, 41'sd28524006506, 41'sd15071301663, 41'sd7650428050,
    41'sd3840059795,  41'sd1921901881,  41'sd961185452,   41'sd480622056,
    41'sd240314695,   41'sd120157806,   41'sd60078960,    41'sd30039487,
    41'sd15019745,    41'sd7509872,     41'sd3754936,     41'sd1877468,
    41'sd938734,      41'sd469367,      41'sd234684,      41'sd117342,
    41'sd58671,       41'sd29335,       41'sd14668,       41'sd7334,
    41'sd3667,        41'sd1833,        41'sd917,         41'sd458,
    41'sd229,         41'sd115,         41'sd57,          41'sd29
  };

  // Per-item status carried alongside the datapath.
  typedef struct packed {
    logic xy_zero;  // x and y both zero: fixed angles apply
    logic z_pos;    // z strictly positive
  } dtyp_flags_t;

  localparam int unsigned FLAGS_W = $bits(dtyp_flags_t);

endpackage

[hdl/direction_to_yaw_pitch.sv]
// Top level of the direction-to-yaw/pitch converter.
// Instantiates dtyp_norm, two chains of dtyp_cordic_cell and dtyp_gain;
// depends on dtyp_pkg.
//
// Converts a signed direction vector (units of 1/256) into yaw = atan2(y, x)
// and pitch = atan2(-z, |(x, y)|), both unsigned degrees in [0, 360) with
// ANGLE_FRAC_BITS fraction bits. When x and y are both zero, yaw is 0 and
// pitch is 270 for positive z, else 90. The datapath is a fully pipelined
// chain: three front-end stages, CORDIC_STAGES cells for yaw, two gain
// correction stages, CORDIC_STAGES cells for pitch and one output register.
// One vector is taken every clock; each cell holds one item, and ready
// ripples back through the chain, so a stalled output only stops input once
// every cell is full.
module direction_to_yaw_pitch #(
  parameter int unsigned COMPONENT_BITS  = 24,
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned CORDIC_STAGES   = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              dir_valid_i,
  output logic                              dir_ready_o,
  input  logic signed [COMPONENT_BITS-1:0]  dir_x_i,
  input  logic signed [COMPONENT_BITS-1:0]  dir_y_i,
  input  logic signed [COMPONENT_BITS-1:0]  dir_z_i,
  output logic                              angle_valid_o,
  input  logic                              angle_ready_i,
  output logic [9+ANGLE_FRAC_BITS-1:0]      pitch_angle_o,
  output logic [9+ANGLE_FRAC_BITS-1:0]      yaw_angle_o
);
  import dtyp_pkg::*;

  localparam int unsigned OUT_W    = 9 + ANGLE_FRAC_BITS;
  localparam int unsigned ROUND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (ROUND_SH - 1);
  localparam logic signed [ACC_W-1:0] FULL_TURN  = ACC_W'(360) << ANGLE_FRAC_BITS;
  localparam logic [OUT_W-1:0] PITCH_DOWN = OUT_W'(270) << ANGLE_FRAC_BITS;
  localparam logic [OUT_W-1:0] PITCH_UP   = OUT_W'(90) << ANGLE_FRAC_BITS;

  // Side data: pass one carries -z and flags; gain adds yaw; pass two carries yaw and flags.
  localparam int unsigned SIDE1_W = VEC_W + FLAGS_W;
  localparam int unsigned SIDE2_W = ACC_W + FLAGS_W;
  localparam int unsigned SIDEG_W = VEC_W + ACC_W + FLAGS_W;

  // Round Q.30 to the output fraction and wrap into [0, 360).
  function automatic logic [OUT_W-1:0] finish_angle(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    r = (acc + ROUND_BIAS) >>> ROUND_SH;
    if (r < 0) begin
      r = r + FULL_TURN;
    end else if (r >= FULL_TURN) begin
      r = r - FULL_TURN;
    end
    return r[OUT_W-1:0];
  endfunction

  // Front end.
  logic                    n_valid;
  logic signed [VEC_W-1:0] n_x, n_y, n_pz;
  logic signed [ACC_W-1:0] n_acc;
  dtyp_flags_t             n_flags;

  // First CORDIC pass (yaw).
  logic                    c1_valid [CORDIC_STAGES+1];
  logic                    c1_ready [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] c1_x     [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] c1_y     [CORDIC_STAGES+1];
  logic signed [ACC_W-1:0] c1_acc   [CORDIC_STAGES+1];
  logic [SIDE1_W-1:0]      c1_side  [CORDIC_STAGES+1];

  // Gain correction.
  logic                    g_valid, g_ready;
  logic signed [VEC_W-1:0] g_r;
  logic [SIDEG_W-1:0]      g_side;

  // Second CORDIC pass (pitch).
  logic                    c2_valid [CORDIC_STAGES+1];
  logic                    c2_ready [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] c2_x     [CORDIC_STAGES+1];
  logic signed [VEC_W-1:0] c2_y     [CORDIC_STAGES+1];
  logic signed [ACC_W-1:0] c2_acc   [CORDIC_STAGES+1];
  logic [SIDE2_W-1:0]      c2_side  [CORDIC_STAGES+1];

  // Output register.
  logic                    out_valid_q, out_ready;
  logic [OUT_W-1:0]        pitch_d, yaw_d, pitch_q, yaw_q;
  logic signed [ACC_W-1:0] yaw_acc_end;
  dtyp_flags_t             flags_end;

  dtyp_norm #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dir_valid_i),
    .ready_o (dir_ready_o),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (n_valid),
    .ready_i (c1_ready[0]),
    .x_o     (n_x),
    .y_o     (n_y),
    .pz_o    (n_pz),
    .acc_o   (n_acc),
    .flags_o (n_flags)
  );

  assign c1_valid[0] = n_valid;
  assign c1_x[0]     = n_x;
  assign c1_y[0]     = n_y;
  assign c1_acc[0]   = n_acc;
  assign c1_side[0]  = {n_pz, n_flags};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pass1
    dtyp_cordic_cell #(
      .STAGE  (i),
      .SIDE_W (SIDE1_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c1_valid[i]),
      .ready_o (c1_ready[i]),
      .x_i     (c1_x[i]),
      .y_i     (c1_y[i]),
      .acc_i   (c1_acc[i]),
      .side_i  (c1_side[i]),
      .valid_o (c1_valid[i+1]),
      .ready_i (c1_ready[i+1]),
      .x_o     (c1_x[i+1]),
      .y_o     (c1_y[i+1]),
      .acc_o   (c1_acc[i+1]),
      .side_o  (c1_side[i+1])
    );
  end

  dtyp_gain #(
    .SIDE_W (SIDEG_W)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1_valid[CORDIC_STAGES]),
    .ready_o (c1_ready[CORDIC_STAGES]),
    .x_i     (c1_x[CORDIC_STAGES]),
    .side_i  ({c1_side[CORDIC_STAGES][SIDE1_W-1:FLAGS_W], c1_acc[CORDIC_STAGES],
               c1_side[CORDIC_STAGES][FLAGS_W-1:0]}),
    .valid_o (g_valid),
    .ready_i (g_ready),
    .r_o     (g_r),
    .side_o  (g_side)
  );

  // Pass two rotates (length, -z); pass-one residual y is not needed.
  assign c2_valid[0] = g_valid;
  assign g_ready     = c2_ready[0];
  assign c2_x[0]     = g_r;
  assign c2_y[0]     = g_side[SIDEG_W-1:SIDE2_W];
  assign c2_acc[0]   = '0;
  assign c2_side[0]  = g_side[SIDE2_W-1:0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pass2
    dtyp_cordic_cell #(
      .STAGE  (i),
      .SIDE_W (SIDE2_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c2_valid[i]),
      .ready_o (c2_ready[i]),
      .x_i     (c2_x[i]),
      .y_i     (c2_y[i]),
      .acc_i   (c2_acc[i]),
      .side_i  (c2_side[i]),
      .valid_o (c2_valid[i+1]),
      .ready_i (c2_ready[i+1]),
      .x_o     (c2_x[i+1]),
      .y_o     (c2_y[i+1]),
      .acc_o   (c2_acc[i+1]),
      .side_o  (c2_side[i+1])
    );
  end

  // Final rounding, wrap and the fixed angles for a vertical direction.
  always_comb begin
    yaw_acc_end = c2_side[CORDIC_STAGES][SIDE2_W-1:FLAGS_W];
    flags_end   = dtyp_flags_t'(c2_side[CORDIC_STAGES][FLAGS_W-1:0]);
    if (flags_end.xy_zero) begin
      pitch_d = flags_end.z_pos ? PITCH_DOWN : PITCH_UP;
      yaw_d   = '0;
    end else begin
      pitch_d = finish_angle(c2_acc[CORDIC_STAGES]);
      yaw_d   = finish_angle(yaw_acc_end);
    end
  end

  assign out_ready                = !out_valid_q || angle_ready_i;
  assign c2_ready[CORDIC_STAGES]  = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= c2_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && c2_valid[CORDIC_STAGES]) begin
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign angle_valid_o = out_valid_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule

[hdl/dtyp_cordic_cell.sv]
// One CORDIC vectoring micro-rotation with its own pipeline register.
// Depends on dtyp_pkg for widths and the arctangent table.
module dtyp_cordic_cell #(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [dtyp_pkg::VEC_W-1:0]  x_i,
  input  logic signed [dtyp_pkg::VEC_W-1:0]  y_i,
  input  logic signed [dtyp_pkg::ACC_W-1:0]  acc_i,
  input  logic        [SIDE_W-1:0]           side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [dtyp_pkg::VEC_W-1:0]  x_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]  y_o,
  output logic signed [dtyp_pkg::ACC_W-1:0]  acc_o,
  output logic        [SIDE_W-1:0]           side_o
);
  import dtyp_pkg::*;

  localparam logic signed [ACC_W-1:0] ANGLE_STEP = ATAN_DEG[STAGE];

  logic                    valid_q;
  logic signed [VEC_W-1:0] x_q, y_q, x_d, y_d;
  logic signed [VEC_W-1:0] x_shift, y_shift;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic        [SIDE_W-1:0] side_q;

  // Rotate toward the x axis: the sign of y picks the direction.
  always_comb begin
    x_shift = x_i >>> STAGE;
    y_shift = y_i >>> STAGE;
    if (!y_i[VEC_W-1]) begin
      x_d   = x_i + y_shift;
      y_d   = y_i - x_shift;
      acc_d = acc_i + ANGLE_STEP;
    end else begin
      x_d   = x_i - y_shift;
      y_d   = y_i + x_shift;
      acc_d = acc_i - ANGLE_STEP;
    end
  end

  // The cell takes a new item when empty or when its item moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

[hdl/dtyp_norm.sv]
// Front end: input register, normalization shift search, scaling and
// half-plane fold ahead of the first CORDIC pass. Depends on dtyp_pkg.
module dtyp_norm #(
  parameter int unsigned COMPONENT_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [COMPONENT_BITS-1:0]   dir_x_i,
  input  logic signed [COMPONENT_BITS-1:0]   dir_y_i,
  input  logic signed [COMPONENT_BITS-1:0]   dir_z_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [dtyp_pkg::VEC_W-1:0]  x_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]  y_o,
  output logic signed [dtyp_pkg::VEC_W-1:0]  pz_o,
  output logic signed [dtyp_pkg::ACC_W-1:0]  acc_o,
  output dtyp_pkg::dtyp_flags_t              flags_o
);
  import dtyp_pkg::*;

  // Stage A: inputs, magnitudes ORed together, flags.
  logic                             valid_a_q, ready_a;
  logic signed [COMPONENT_BITS-1:0] x_a_q, y_a_q, z_a_q;
  logic        [COMPONENT_BITS-1:0] mag_x, mag_y, mag_z, mag_or_q;
  dtyp_flags_t                      flags_a_d, flags_a_q;

  // Stage B: shift amount.
  logic                             valid_b_q, ready_b;
  logic signed [COMPONENT_BITS-1:0] x_b_q, y_b_q, z_b_q;
  logic        [SHIFT_W-1:0]        msb, shift_d, shift_b_q;
  dtyp_flags_t                      flags_b_q;

  // Stage C: scaled and folded vector.
  logic                    valid_c_q, ready_c;
  logic signed [VEC_W-1:0] x_sh, y_sh, z_sh;
  logic signed [VEC_W-1:0] x_d, y_d, pz_d, x_c_q, y_c_q, pz_c_q;
  logic signed [ACC_W-1:0] acc_d, acc_c_q;
  dtyp_flags_t             flags_c_q;

  // The msb of the largest magnitude equals the msb of their OR.
  always_comb begin
    mag_x = dir_x_i[COMPONENT_BITS-1] ? COMPONENT_BITS'(-dir_x_i) : COMPONENT_BITS'(dir_x_i);
    mag_y = dir_y_i[COMPONENT_BITS-1] ? COMPONENT_BITS'(-dir_y_i) : COMPONENT_BITS'(dir_y_i);
    mag_z = dir_z_i[COMPONENT_BITS-1] ? COMPONENT_BITS'(-dir_z_i) : COMPONENT_BITS'(dir_z_i);
    flags_a_d.xy_zero = (dir_x_i == '0) && (dir_y_i == '0);
    flags_a_d.z_pos   = !dir_z_i[COMPONENT_BITS-1] && (dir_z_i != '0);
  end

  // Priority encoder and the shift that lifts that msb to NORM_MSB.
  always_comb begin
    msb = '0;
    for (int b = 0; b < COMPONENT_BITS; b++) begin
      if (mag_or_q[b]) begin
        msb = SHIFT_W'(b);
      end
    end
    shift_d = (msb >= SHIFT_W'(NORM_MSB)) ? '0 : SHIFT_W'(NORM_MSB) - msb;
  end

  // Scale all three components, then fold x < 0 into the right half plane.
  always_comb begin
    x_sh = VEC_W'(x_b_q) <<< shift_b_q;
    y_sh = VEC_W'(y_b_q) <<< shift_b_q;
    z_sh = VEC_W'(z_b_q) <<< shift_b_q;
    pz_d = -z_sh;
    if (x_sh[VEC_W-1]) begin
      x_d   = -x_sh;
      y_d   = -y_sh;
      acc_d = ACC_HALF_TURN;
    end else begin
      x_d   = x_sh;
      y_d   = y_sh;
      acc_d = '0;
    end
  end

  // Each stage advances when empty or when its item moves on.
  assign ready_c = !valid_c_q || ready_i;
  assign ready_b = !valid_b_q || ready_c;
  assign ready_a = !valid_a_q || ready_b;
  assign ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
      if (ready_c) begin
        valid_c_q <= valid_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      x_a_q     <= dir_x_i;
      y_a_q     <= dir_y_i;
      z_a_q     <= dir_z_i;
      mag_or_q  <= mag_x | mag_y | mag_z;
      flags_a_q <= flags_a_d;
    end
    if (ready_b && valid_a_q) begin
      x_b_q     <= x_a_q;
      y_b_q     <= y_a_q;
      z_b_q     <= z_a_q;
      shift_b_q <= shift_d;
      flags_b_q <= flags_a_q;
    end
    if (ready_c && valid_b_q) begin
      x_c_q     <= x_d;
      y_c_q     <= y_d;
      pz_c_q    <= pz_d;
      acc_c_q   <= acc_d;
      flags_c_q <= flags_b_q;
    end
  end

  assign valid_o = valid_c_q;
  assign x_o     = x_c_q;
  assign y_o     = y_c_q;
  assign pz_o    = pz_c_q;
  assign acc_o   = acc_c_q;
  assign flags_o = flags_c_q;

endmodule

[hdl/dtyp_gain.sv]
// CORDIC gain correction: multiplies the pass-one length by 1/K in two
// registered steps (partial products, then sum and round). Uses dtyp_pkg.
module dtyp_gain #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [dtyp_pkg::VEC_W-1:0]  x_i,
  input  logic        [SIDE_W-1:0]           side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [dtyp_pkg::VEC_W-1:0]  r_o,
  output logic        [SIDE_W-1:0]           side_o
);
  import dtyp_pkg::*;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ACC_FRAC - 1);

  logic                 valid_p_q, ready_p;
  logic [PP_LO_W-1:0]   pp_lo_q;
  logic [PP_HI_W-1:0]   pp_hi_q;
  logic [SIDE_W-1:0]    side_p_q;

  logic                 valid_r_q, ready_r;
  logic [PROD_W-1:0]    sum;
  logic signed [VEC_W-1:0] r_q;
  logic [SIDE_W-1:0]    side_r_q;

  // The length is never negative, so its low bits are taken as unsigned.
  always_comb begin
    sum = (PROD_W'(pp_hi_q) << GAIN_LO_W) + PROD_W'(pp_lo_q) + ROUND_HALF;
  end

  assign ready_r = !valid_r_q || ready_i;
  assign ready_p = !valid_p_q || ready_r;
  assign ready_o = ready_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
      valid_r_q <= 1'b0;
    end else begin
      if (ready_p) begin
        valid_p_q <= valid_i;
      end
      if (ready_r) begin
        valid_r_q <= valid_p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_p && valid_i) begin
      pp_lo_q  <= PP_LO_W'(x_i[GAIN_LO_W-1:0]) * PP_LO_W'(KINV_Q30);
      pp_hi_q  <= PP_HI_W'(x_i[VEC_W-2:GAIN_LO_W]) * PP_HI_W'(KINV_Q30);
      side_p_q <= side_i;
    end
    if (ready_r && valid_p_q) begin
      r_q      <= {1'b0, sum[PROD_W-1:ACC_FRAC]};
      side_r_q <= side_p_q;
    end
  end

  assign valid_o = valid_r_q;
  assign r_o     = r_q;
  assign side_o  = side_r_q;

endmodule

[verif/tb_direction_to_yaw_pitch.sv]
// Testbench for direction_to_yaw_pitch: directed and random direction vectors,
// each result checked against a fixed-point CORDIC predictor of yaw and pitch.
// Depends only on the block's RTL and its package dtyp_pkg.
module tb_direction_to_yaw_pitch;

  localparam int unsigned COMP_W           = 24;
  localparam int unsigned FRAC_W           = 16;
  localparam int unsigned STAGES           = 20;
  localparam int unsigned ANGLE_W          = 9 + FRAC_W;
  localparam int unsigned LATENCY          = 2 * STAGES + 6;
  localparam int unsigned IDLE_LIMIT       = 2000;
  localparam int unsigned RANDOM_PER_PHASE = 275;
  localparam int unsigned NUM_PHASES       = 4;
  localparam int unsigned NUM_DIRECTED     = 24;

  // Accumulator is degrees with 30 fraction bits; 1/K of the CORDIC gain in Q.30.
  localparam int unsigned     ACC_FRAC     = 30;
  localparam longint unsigned GAIN_INV_Q30 = 64'd652032874;
  localparam longint          ANGLE_FULL   = longint'(360) << FRAC_W;

  // atan(2^-i) in degrees, Q.30.
  localparam longint ATAN_Q30 [20] = '{
    64'sd48318382080, 64'sd28524006506, 64'sd15071301663, 64'sd7650428050,
    64'sd3840059795,  64'sd1921901881,  64'sd961185452,   64'sd480622056,
    64'sd240314695,   64'sd120157806,   64'sd60078960,    64'sd30039487,
    64'sd15019745,    64'sd7509872,     64'sd3754936,     64'sd1877468,
    64'sd938734,      64'sd469367,      64'sd234684,      64'sd117342
  };

  // Pacing per phase: free flow, sender gaps, receiver stalls, both mixed.
  localparam int unsigned SEND_IDLE  [NUM_PHASES] = '{0, 78, 0, 17};
  localparam int unsigned RECV_STALL [NUM_PHASES] = '{0, 0, 78, 17};

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } dir_vec_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] yaw;
  } angle_pair_t;

  localparam logic signed [COMP_W-1:0] C_MAX  = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] C_MIN  = {1'b1, {(COMP_W-1){1'b0}}};
  localparam logic signed [COMP_W-1:0] C_ONE  = {{(COMP_W-1){1'b0}}, 1'b1};
  localparam logic signed [COMP_W-1:0] C_NEG1 = {COMP_W{1'b1}};
  localparam logic signed [COMP_W-1:0] C_ZERO = {COMP_W{1'b0}};

  // Axis cases, extreme components, octant boundaries and angles near the wrap.
  localparam dir_vec_t DIRECTED [NUM_DIRECTED] = '{
    '{C_ZERO, C_ZERO, C_ZERO}, '{C_ZERO, C_ZERO, C_ONE},  '{C_ZERO, C_ZERO, C_NEG1},
    '{C_ZERO, C_ZERO, C_MAX},  '{C_ZERO, C_ZERO, C_MIN},  '{C_ONE, C_ZERO, C_ZERO},
    '{C_NEG1, C_ZERO, C_ZERO}, '{C_ZERO, C_ONE, C_ZERO},  '{C_ZERO, C_NEG1, C_ZERO},
    '{C_MAX, C_ZERO, C_ZERO},  '{C_MIN, C_ZERO, C_ZERO},  '{C_ZERO, C_MAX, C_ZERO},
    '{C_ZERO, C_MIN, C_ZERO},  '{C_MAX, C_MAX, C_MAX},    '{C_MIN, C_MIN, C_MIN},
    '{C_MIN, C_MAX, C_MIN},    '{C_MAX, C_MIN, C_MAX},    '{C_ONE, C_ONE, C_ONE},
    '{C_NEG1, C_NEG1, C_NEG1}, '{C_NEG1, C_ONE, C_NEG1},  '{C_MIN, C_NEG1, C_ZERO},
    '{C_MAX, C_NEG1, C_ZERO},  '{C_ONE, C_ZERO, C_MAX},   '{C_NEG1, C_ZERO, C_MIN}
  };

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     dir_valid_i   = 1'b0;
  logic                     dir_ready_o;
  logic signed [COMP_W-1:0] dir_x_i       = '0;
  logic signed [COMP_W-1:0] dir_y_i       = '0;
  logic signed [COMP_W-1:0] dir_z_i       = '0;
  logic                     angle_valid_o;
  logic                     angle_ready_i = 1'b0;
  logic [ANGLE_W-1:0]       pitch_angle_o;
  logic [ANGLE_W-1:0]       yaw_angle_o;

  dir_vec_t    dir_pending_q [$];
  angle_pair_t angle_expect_q [$];
  dir_vec_t    dir_next;
  angle_pair_t angle_exp;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;
  int unsigned pairs_checked  = 0;
  int unsigned dirs_sent      = 0;
  int unsigned axis_dirs      = 0;

  direction_to_yaw_pitch #(
    .COMPONENT_BITS  (COMP_W),
    .ANGLE_FRAC_BITS (FRAC_W),
    .CORDIC_STAGES   (STAGES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dir_valid_i   (dir_valid_i),
    .dir_ready_o   (dir_ready_o),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .angle_valid_o (angle_valid_o),
    .angle_ready_i (angle_ready_i),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

  // One vectoring pass: rotates (vx, vy) onto the positive x axis and sums the angle.
  function automatic longint cordic_vectoring(inout longint vx, inout longint vy,
                                              input longint acc);
    longint xs, ys;
    for (int i = 0; i < STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx += ys;
        vy -= xs;
        acc += ATAN_Q30[i];
      end else begin
        vx -= ys;
        vy += xs;
        acc -= ATAN_Q30[i];
      end
    end
    return acc;
  endfunction

  // Round half up to the output fraction and fold into [0, 360).
  function automatic logic [ANGLE_W-1:0] round_angle(longint acc);
    longint r;
    r = (acc + (longint'(1) << (ACC_FRAC - FRAC_W - 1))) >>> (ACC_FRAC - FRAC_W);
    if (r < 0) r += ANGLE_FULL;
    if (r >= ANGLE_FULL) r -= ANGLE_FULL;
    return r[ANGLE_W-1:0];
  endfunction

  // Expected yaw and pitch for one direction vector.
  function automatic angle_pair_t predict_angles(dir_vec_t v);
    angle_pair_t     res;
    longint          x, y, z, len, neg_z, yaw_acc, pitch_acc, fixed;
    longint unsigned m, prod;
    int              shift;
    x = longint'($signed(v.x));
    y = longint'($signed(v.y));
    z = longint'($signed(v.z));
    // On the z axis the angles are fixed.
    if (x == 0 && y == 0) begin
      fixed = longint'((z > 0) ? 270 : 90) << FRAC_W;
      res.pitch = fixed[ANGLE_W-1:0];
      res.yaw = '0;
      return res;
    end
    // Normalize so the largest magnitude reaches bit 30.
    m = $unsigned((x < 0) ? -x : x);
    if ($unsigned((y < 0) ? -y : y) > m) m = $unsigned((y < 0) ? -y : y);
    if ($unsigned((z < 0) ? -z : z) > m) m = $unsigned((z < 0) ? -z : z);
    shift = 0;
    while (m < (64'd1 << 30) && shift < 40) begin
      m <<= 1;
      shift++;
    end
    x = x <<< shift;
    y = y <<< shift;
    z = z <<< shift;
    // Left half plane: mirror the vector and start yaw at 180 degrees.
    yaw_acc = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      yaw_acc = longint'(180) << ACC_FRAC;
    end
    yaw_acc = cordic_vectoring(x, y, yaw_acc);
    // Remove the CORDIC gain from the horizontal length before the pitch pass.
    prod = $unsigned(x) * GAIN_INV_Q30 + (64'd1 << (ACC_FRAC - 1));
    len = longint'(prod >> ACC_FRAC);
    neg_z = -z;
    pitch_acc = cordic_vectoring(len, neg_z, 0);
    res.pitch = round_angle(pitch_acc);
    res.yaw = round_angle(yaw_acc);
    return res;
  endfunction

  // Mix of zero, tiny, extreme, scaled and fully random component values.
  function automatic logic signed [COMP_W-1:0] rand_component();
    int v;
    v = int'($urandom);
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = int'($urandom_range(0, 16)) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return C_MAX;
          1: return C_MIN;
          2: return C_ONE;
          default: return C_NEG1;
        endcase
      end
      3: begin
        v = int'($urandom >> $urandom_range(8, 31));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: ;
    endcase
    return v[COMP_W-1:0];
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Driver: record the prediction on each input transfer, then offer the next vector.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (dir_valid_i && dir_ready_o) begin
        angle_expect_q.push_back(predict_angles(dir_vec_t'({dir_x_i, dir_y_i, dir_z_i})));
        dirs_sent++;
        if (dir_x_i == 0 && dir_y_i == 0) axis_dirs++;
      end
      if (!dir_valid_i || dir_ready_o) begin
        if (dir_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          dir_next = dir_pending_q.pop_front();
          dir_valid_i <= 1'b1;
          dir_x_i <= dir_next.x;
          dir_y_i <= dir_next.y;
          dir_z_i <= dir_next.z;
        end else begin
          dir_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (angle_valid_o && angle_ready_i) begin
        if (angle_expect_q.size() == 0) begin
          $error("Unexpected result: pitch_angle %0d yaw_angle %0d",
                 pitch_angle_o, yaw_angle_o);
          mismatches++;
        end else begin
          angle_exp = angle_expect_q.pop_front();
          if (pitch_angle_o !== angle_exp.pitch) begin
            $error("pitch_angle mismatch: expected %0d, actual %0d",
                   angle_exp.pitch, pitch_angle_o);
            mismatches++;
          end
          if (yaw_angle_o !== angle_exp.yaw) begin
            $error("yaw_angle mismatch: expected %0d, actual %0d",
                   angle_exp.yaw, yaw_angle_o);
            mismatches++;
          end
        end
        pairs_checked++;
      end
      angle_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((dir_valid_i && dir_ready_o) || (angle_valid_o && angle_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $error("No transfer for %0d cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus: reset, then one phase per pacing setting, draining fully between phases.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk_i);
      send_idle_pct = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == 0) begin
        foreach (DIRECTED[i]) dir_pending_q.push_back(DIRECTED[i]);
      end
      repeat (RANDOM_PER_PHASE) begin
        dir_pending_q.push_back(dir_vec_t'({rand_component(), rand_component(),
                                            rand_component()}));
      end
      // The next phase starts only once every queued vector is sent and every expected result is back.
      while (dir_pending_q.size() != 0 || dir_valid_i || angle_expect_q.size() != 0)
        @(negedge clk_i);
    end
    repeat (LATENCY + 14) @(negedge clk_i);
    $display("Checked %0d yaw/pitch pairs from %0d directions, %0d of them on the z axis,",
             pairs_checked, dirs_sent, axis_dirs);
    $display("under free flow, sender gaps, receiver stalls and both combined.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
